### rtl/ufr_pkg.sv
// shared types and constants for the framed link receiver with ping responder
package ufr_pkg;

    // parser position within a frame
    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_CODE    = 2'd1,
        PH_CHECK   = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_CODE     = 2'd1;

    // configuration reset values
    localparam logic [15:0] TIMEOUT_RESET   = 16'd100;
    localparam logic [7:0]  PING_CODE_RESET = 8'd0;

    // reply frame constants
    localparam logic [7:0]  REPLY_CRC_SEED = 8'd1;
    localparam logic [7:0]  REPLY_STATUS   = 8'd1;
    localparam logic [15:0] IDLE_MAX       = 16'hffff;

    // reply launch from parser to serializer
    typedef struct packed {
        logic       load;
        logic [7:0] code;
        logic [7:0] crc;
    } ufr_reply_t;

endpackage

### rtl/ufr_parser.sv
// frame parser: header and payload tracking, idle timeout, reply launch
module ufr_parser #(
    parameter int MAC_BYTES = 6
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     accept,
    input  logic                     in_command,
    input  logic [7:0]               in_byte,
    input  logic [15:0]              timeout_ticks,
    input  logic [7:0]               ping_code,
    output logic                     done_possible,
    output ufr_pkg::ufr_reply_t      reply,
    output logic [MAC_BYTES*8-1:0]   mac_bytes
);
    import ufr_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [7:0]          length_reg, length_next;
    logic [7:0]          code_reg, code_next;
    logic [7:0]          expect_reg, expect_next;
    logic [7:0]          count_reg, count_next;
    logic [7:0]          sum_reg, sum_next;
    logic [7:0]          mac_sum_reg, mac_sum_next;
    logic [15:0]         idle_reg, idle_next;
    logic [MAC_BYTES*8-1:0] mac_reg, mac_next;

    logic                is_tick;
    logic                is_byte;
    logic [15:0]         idle_inc;
    logic                timeout_hit;
    logic [7:0]          count_inc;
    logic                frame_done;

    // decode of the current transaction
    assign is_tick     = accept && in_command;
    assign is_byte     = accept && !in_command;
    assign idle_inc    = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;
    assign timeout_hit = idle_inc >= timeout_ticks;
    assign count_inc   = count_reg + 8'd1;

    // frame can complete on the next received byte
    assign done_possible = ((phase_reg == PH_CHECK) && (length_reg == 8'd0)) ||
                           ((phase_reg == PH_PAYLOAD) && (count_inc == length_reg));
    assign frame_done    = is_byte && done_possible;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (is_tick) begin
            if (timeout_hit) begin
                phase_next = PH_LENGTH;
            end
        end else if (is_byte) begin
            case (phase_reg)
                PH_LENGTH:  phase_next = PH_CODE;
                PH_CODE:    phase_next = PH_CHECK;
                PH_CHECK:   phase_next = frame_done ? PH_LENGTH : PH_PAYLOAD;
                PH_PAYLOAD: phase_next = frame_done ? PH_LENGTH : PH_PAYLOAD;
                default:    phase_next = PH_LENGTH;
            endcase
        end
    end

    // header, payload and idle datapath
    always_comb begin
        length_next  = length_reg;
        code_next    = code_reg;
        expect_next  = expect_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        mac_sum_next = mac_sum_reg;
        idle_next    = idle_reg;
        mac_next     = mac_reg;
        if (is_tick) begin
            if (timeout_hit) begin
                count_next = 8'd0;
                sum_next   = 8'd0;
                idle_next  = 16'd0;
            end else begin
                idle_next = idle_inc;
            end
        end else if (is_byte) begin
            case (phase_reg)
                PH_LENGTH: begin
                    length_next  = in_byte;
                    count_next   = 8'd0;
                    sum_next     = 8'd0;
                    mac_sum_next = 8'd0;
                    mac_next     = '0;
                end
                PH_CODE: begin
                    code_next = in_byte;
                end
                PH_CHECK: begin
                    expect_next = in_byte;
                end
                PH_PAYLOAD: begin
                    for (int i = 0; i < MAC_BYTES; i++) begin
                        if (count_reg == 8'(i)) begin
                            mac_next[i*8 +: 8] = in_byte;
                            mac_sum_next       = mac_sum_reg + in_byte;
                        end
                    end
                    sum_next   = sum_reg + in_byte;
                    count_next = count_inc;
                end
                default: begin
                    length_next = length_reg;
                end
            endcase
            if (frame_done) begin
                idle_next = 16'd0;
            end
        end
    end

    // reply launch on a good ping frame
    assign reply.load = frame_done && (sum_next == expect_next) && (code_reg == ping_code);
    assign reply.code = ping_code;
    assign reply.crc  = REPLY_CRC_SEED + mac_sum_next;
    assign mac_bytes  = mac_next;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LENGTH;
            length_reg <= 8'd0;
            count_reg  <= 8'd0;
            sum_reg    <= 8'd0;
            idle_reg   <= 16'd0;
        end else begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            idle_reg   <= idle_next;
        end
    end

    // header and kept-byte registers
    always_ff @(posedge aclk) begin
        code_reg    <= code_next;
        expect_reg  <= expect_next;
        mac_sum_reg <= mac_sum_next;
        mac_reg     <= mac_next;
    end

endmodule

### rtl/ufr_tx.sv
// reply serializer: holds one reply frame and sends it a byte per transaction
module ufr_tx #(
    parameter int MAC_BYTES = 6
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ufr_pkg::ufr_reply_t      reply,
    input  logic [MAC_BYTES*8-1:0]   mac_bytes,
    output logic                     busy,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_tx_byte,
    output logic                     m_last
);
    import ufr_pkg::*;

    localparam int          REPLY_LEN = MAC_BYTES + 4;
    localparam int          IDX_W     = $clog2(REPLY_LEN);
    localparam logic [7:0]  LEN_BYTE  = 8'(MAC_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(REPLY_LEN - 1);

    logic                   busy_reg, busy_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [7:0]             code_reg;
    logic [7:0]             crc_reg;
    logic [MAC_BYTES*8-1:0] mac_reg;
    logic                   advance;

    assign advance = busy_reg && m_ready;

    // byte position and busy flag
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (reply.load) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (advance) begin
            if (idx_reg == IDX_LAST) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // reply snapshot
    always_ff @(posedge aclk) begin
        if (reply.load) begin
            code_reg <= reply.code;
            crc_reg  <= reply.crc;
            mac_reg  <= mac_bytes;
        end
    end

    // byte select
    always_comb begin
        m_tx_byte = LEN_BYTE;
        if (idx_reg == IDX_W'(1)) begin
            m_tx_byte = code_reg;
        end else if (idx_reg == IDX_W'(2)) begin
            m_tx_byte = crc_reg;
        end else if (idx_reg == IDX_LAST) begin
            m_tx_byte = REPLY_STATUS;
        end else begin
            for (int i = 0; i < MAC_BYTES; i++) begin
                if (idx_reg == IDX_W'(i + 3)) begin
                    m_tx_byte = mac_reg[i*8 +: 8];
                end
            end
        end
    end

    assign m_last  = (idx_reg == IDX_LAST);
    assign m_valid = busy_reg;
    assign busy    = busy_reg;

endmodule

### rtl/uart_frame_receiver_ping_responder_unit.sv
// top level of the framed link receiver with ping responder
//
// Input channel (s_): one transaction is either a received link byte
// (s_command = 0, s_rx_byte) or one time tick (s_command = 1).
// Output channel (m_): reply frame bytes, m_last on the status byte.
// Configuration channel (cfg_): cfg_index 0 writes timeout_ticks from
// cfg_data, index 1 writes ping_code from cfg_data[7:0]; always ready.
//
// Throughput: one input transaction per cycle. The parser updates its
// registers in the accepting cycle; a good ping frame loads the reply
// register at that edge and its first byte is offered the next cycle.
// The reply is MAC_BYTES+4 bytes at one byte per cycle while m_ready is
// high, sent from the single reply register in the serializer.
// Input is held off only when a reply is still being sent and the next
// byte could complete another frame; otherwise input keeps flowing.
// When the receiver stalls, the current reply byte holds until taken.
// Reset: parser expects a length byte, idle count zero, no reply pending,
// timeout_ticks = 100, ping_code = 0.
module uart_frame_receiver_ping_responder_unit #(
    parameter int MAC_BYTES = 6
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_command,
    input  logic [7:0]                      s_rx_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_tx_byte,
    output logic                            m_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ufr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                     cfg_data
);
    import ufr_pkg::*;

    logic [15:0]            timeout_reg;
    logic [7:0]             ping_reg;
    logic                   s_accept;
    logic                   done_possible;
    logic                   tx_busy;
    ufr_reply_t             reply;
    logic [MAC_BYTES*8-1:0] mac_bytes;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            ping_reg    <= PING_CODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TIMEOUT_TICKS: timeout_reg <= cfg_data;
                CFG_PING_CODE:     ping_reg    <= cfg_data[7:0];
                default:           ping_reg    <= ping_reg;
            endcase
        end
    end

    // input flow control
    assign s_ready  = !(tx_busy && done_possible);
    assign s_accept = s_valid && s_ready;

    ufr_parser #(
        .MAC_BYTES (MAC_BYTES)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_accept),
        .in_command    (s_command),
        .in_byte       (s_rx_byte),
        .timeout_ticks (timeout_reg),
        .ping_code     (ping_reg),
        .done_possible (done_possible),
        .reply         (reply),
        .mac_bytes     (mac_bytes)
    );

    ufr_tx #(
        .MAC_BYTES (MAC_BYTES)
    ) u_tx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .reply     (reply),
        .mac_bytes (mac_bytes),
        .busy      (tx_busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_tx_byte (m_tx_byte),
        .m_last    (m_last)
    );

endmodule

### rtl/ufr_checker.sv
// port-level checks for the ping responder, bound to the top level
module ufr_checker #(
    parameter int MAC_BYTES = 6
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_command,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [7:0]                    m_tx_byte,
    input logic                          m_last
);
    localparam logic [7:0] LEN_BYTE = 8'(MAC_BYTES + 1);

    // no reply is pending right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("reply pending after reset");

    // stalled reply byte holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_last))
        else $error("reply byte changed while stalled");

    // a tick never starts a reply
    a_tick_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && s_valid && s_ready && s_command |=> !m_valid)
        else $error("reply started by a tick");

    // reply ends after its last byte unless a link byte is accepted with it
    a_reply_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last && !(s_valid && s_ready && !s_command)
        |=> !m_valid)
        else $error("reply continued past its last byte");

    // a reply opens with its length byte
    a_reply_head: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_tx_byte == LEN_BYTE) && !m_last)
        else $error("reply does not open with the length byte");

endmodule

bind uart_frame_receiver_ping_responder_unit ufr_checker #(
    .MAC_BYTES (MAC_BYTES)
) u_ufr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_command (s_command),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_tx_byte (m_tx_byte),
    .m_last    (m_last)
);

### tb/tb_uart_frame_receiver_ping_responder_unit.sv
// testbench for the framed link receiver with ping responder: directed frames, random traffic
module tb_uart_frame_receiver_ping_responder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ufr_pkg::*;

    localparam int MAC_BYTES   = 6;
    localparam int MAC_IDX_W   = $clog2(MAC_BYTES);
    localparam int MAX_GAP     = 18;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 4;
    localparam int FINAL_WAIT  = 20;
    localparam int LONG_LEN    = 40;
    localparam int ROUND_ITEMS = 37;

    // input transaction kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } reply_byte_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_command;
    logic [7:0]           s_rx_byte;
    logic                 m_valid;
    logic                 m_ready;
    logic [7:0]           m_tx_byte;
    logic                 m_last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    // frame parser mirror and register copies
    phase_t      p_phase     = PH_LENGTH;
    logic [7:0]  p_len       = 8'h00;
    logic [7:0]  p_code      = 8'h00;
    logic [7:0]  p_sum_exp   = 8'h00;
    logic [7:0]  p_count     = 8'h00;
    logic [7:0]  p_sum       = 8'h00;
    logic [7:0]  p_mac [MAC_BYTES] = '{default: 8'h00};
    logic [15:0] p_idle      = 16'h0000;
    logic [15:0] cfg_timeout = TIMEOUT_RESET;
    logic [7:0]  cfg_ping    = PING_CODE_RESET;

    // reply bytes still to come, oldest first
    reply_byte_t reply_q [$];
    reply_byte_t reply_head;

    bit src_idle;
    bit snk_idle;
    bit hold_req;
    int stall_cycles;
    int mismatch_count;
    int n_sent;
    int n_ticks;
    int n_frames;
    int n_timeouts;
    int n_reply_bytes;
    int n_cfg_writes;

    uart_frame_receiver_ping_responder_unit #(
        .MAC_BYTES(MAC_BYTES)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_rx_byte (s_rx_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_tx_byte (m_tx_byte),
        .m_last    (m_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #10 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // frame complete: queue the ping reply when checksum and code match
    task automatic close_frame();
        logic [7:0] crc;
        int i;
        p_phase = PH_LENGTH;
        p_idle = 16'h0000;
        n_frames++;
        if (p_sum == p_sum_exp && p_code == cfg_ping) begin
            crc = REPLY_CRC_SEED;
            for (i = 0; i < MAC_BYTES; i++) crc += p_mac[i];
            reply_q.push_back('{8'(MAC_BYTES + 1), 1'b0});
            reply_q.push_back('{cfg_ping, 1'b0});
            reply_q.push_back('{crc, 1'b0});
            for (i = 0; i < MAC_BYTES; i++) reply_q.push_back('{p_mac[i], 1'b0});
            reply_q.push_back('{REPLY_STATUS, 1'b1});
        end
    endtask

    // advance the parser mirror by one accepted input transaction
    task automatic parse_link_item(input logic cmd, input logic [7:0] b);
        int i;
        if (cmd == CMD_TICK) begin
            n_ticks++;
            if (p_idle != IDLE_MAX) p_idle++;
            if (p_idle >= cfg_timeout) begin
                p_phase = PH_LENGTH;
                p_count = 8'h00;
                p_sum = 8'h00;
                p_idle = 16'h0000;
                n_timeouts++;
            end
        end else begin
            case (p_phase)
                PH_LENGTH: begin
                    p_len = b;
                    p_count = 8'h00;
                    p_sum = 8'h00;
                    for (i = 0; i < MAC_BYTES; i++) p_mac[i] = 8'h00;
                    p_phase = PH_CODE;
                end
                PH_CODE: begin
                    p_code = b;
                    p_phase = PH_CHECK;
                end
                PH_CHECK: begin
                    p_sum_exp = b;
                    if (p_len == 8'h00) close_frame();
                    else p_phase = PH_PAYLOAD;
                end
                default: begin
                    if (p_count < MAC_BYTES) p_mac[MAC_IDX_W'(p_count)] = b;
                    p_sum += b;
                    p_count++;
                    if (p_count == p_len) close_frame();
                end
            endcase
        end
    endtask

    // predict on accepted input, check each accepted reply byte
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) parse_link_item(s_command, s_rx_byte);
            if (m_valid && m_ready) begin
                n_reply_bytes++;
                if (reply_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected reply byte 0x%02h last %0b",
                                              m_tx_byte, m_last));
                end else begin
                    reply_head = reply_q.pop_front();
                    if (m_tx_byte !== reply_head.tx_byte)
                        report_mismatch($sformatf("tx_byte got 0x%02h want 0x%02h",
                                                  m_tx_byte, reply_head.tx_byte));
                    if (m_last !== reply_head.last)
                        report_mismatch($sformatf("last got %0b want %0b",
                                                  m_last, reply_head.last));
                end
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // reply receiver with random stalls and the occasional long hold-off
    initial begin : reply_sink
        int gap;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            gap = snk_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // one input transaction; valid stays up across back-to-back items
    task automatic send_item(input logic cmd, input logic [7:0] b);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(CMD_BYTE, b);
    endtask

    // tick with a junk data byte, which must be ignored
    task automatic send_tick();
        send_item(CMD_TICK, 8'($urandom));
    endtask

    // wait out all pending replies, then let the parser settle
    task automatic drain_replies();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        drain_replies();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TIMEOUT_TICKS: cfg_timeout = data;
            CFG_PING_CODE:     cfg_ping = data[7:0];
            default: ;
        endcase
        n_cfg_writes++;
        @(posedge aclk);
    endtask

    // random payload frame; cut drops trailing bytes to leave it partial
    task automatic send_frame(input logic [7:0] code, input int len, input bit good_sum,
                              input bit with_ticks, input int cut);
        logic [7:0] bytes [$];
        logic [7:0] sum;
        int i;
        sum = 8'h00;
        bytes.push_back(8'(len));
        bytes.push_back(code);
        bytes.push_back(8'h00);
        for (i = 0; i < len; i++) begin
            bytes.push_back(8'($urandom));
            sum += bytes[i + 3];
        end
        bytes[2] = good_sum ? sum : (sum ^ 8'($urandom_range(1, 255)));
        for (i = 0; i < bytes.size() - cut; i++) begin
            if (with_ticks && $urandom_range(0, 11) == 0) send_tick();
            send_byte(bytes[i]);
        end
    endtask

    // empty ping payload at the reset ping code, no idling on either side
    task automatic test_empty_ping();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        send_byte(8'h00);
        send_byte(cfg_ping);
        send_byte(8'h00);
    endtask

    // short ping payload: missing kept bytes read as zero
    task automatic test_short_ping();
        src_idle = 1'b1;
        snk_idle = 1'b1;
        send_byte(8'h02);
        send_byte(cfg_ping);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h01);
    endtask

    // payload longer than the kept bytes, new ping code
    task automatic test_long_ping();
        logic [7:0] pay [8];
        logic [7:0] sum;
        int i;
        pay = '{8'h80, 8'h7f, 8'h01, 8'hfe, 8'h55, 8'haa, 8'h33, 8'hcc};
        sum = 8'h00;
        for (i = 0; i < 8; i++) sum += pay[i];
        write_reg(CFG_PING_CODE, {8'($urandom), 8'h5a});
        send_byte(8'h08);
        send_byte(cfg_ping);
        send_byte(sum);
        for (i = 0; i < 8; i++) send_byte(pay[i]);
    endtask

    // bad checksum and foreign command are dropped without a reply
    task automatic test_dropped_frames();
        send_byte(8'h00);
        send_byte(cfg_ping);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(~cfg_ping);
        send_byte(8'h00);
    endtask

    // ticks discard a partial frame once the idle count reaches the limit
    task automatic test_timeout();
        write_reg(CFG_TIMEOUT_TICKS, 16'd3);
        send_byte(8'h04);
        send_byte(cfg_ping);
        repeat (3) send_tick();
        send_frame(cfg_ping, 0, 1'b1, 1'b0, 0);
    endtask

    // long frame far past the kept bytes, largest timeout
    task automatic test_long_frame();
        write_reg(CFG_TIMEOUT_TICKS, 16'hffff);
        send_frame(cfg_ping, LONG_LEN, 1'b1, 1'b0, 0);
    endtask

    // receiver holds off while pings keep coming, so input backs up
    task automatic test_backpressure();
        int k;
        drain_replies();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        hold_req = 1'b1;
        for (k = 0; k < 4; k++) send_frame(cfg_ping, MAC_BYTES, 1'b1, 1'b0, 0);
        drain_replies();
    endtask

    // mostly well-formed frames, plus foreign codes, bad sums, partial frames and ticks
    task automatic run_random_round(input int n_items);
        int stop;
        int pick;
        int len;
        bit sprinkle;
        stop = n_sent + n_items;
        sprinkle = cfg_timeout > 30;
        while (n_sent < stop) begin
            src_idle = $urandom_range(0, 3) != 0;
            snk_idle = $urandom_range(0, 3) != 0;
            pick = $urandom_range(0, 99);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
            if (pick < 60) begin
                send_frame(cfg_ping, len, 1'b1, sprinkle, 0);
            end else if (pick < 72) begin
                send_frame(cfg_ping ^ 8'($urandom_range(1, 255)), len, 1'b1, sprinkle, 0);
            end else if (pick < 84) begin
                send_frame(cfg_ping, len, 1'b0, sprinkle, 0);
            end else if (cfg_timeout <= 16) begin
                send_frame(8'($urandom), len, 1'b1, 1'b0, $urandom_range(1, len + 2));
                repeat (cfg_timeout) send_tick();
            end else begin
                repeat ($urandom_range(1, 3)) send_tick();
            end
        end
    endtask

    task automatic test_random_traffic();
        write_reg(CFG_TIMEOUT_TICKS, TIMEOUT_RESET);
        write_reg(CFG_PING_CODE, 16'h0000);
        run_random_round(ROUND_ITEMS);
        write_reg(CFG_TIMEOUT_TICKS, 16'd1);
        write_reg(CFG_PING_CODE, 16'h00ff);
        run_random_round(ROUND_ITEMS);
        write_reg(CFG_TIMEOUT_TICKS, 16'hffff);
        write_reg(CFG_PING_CODE, 16'($urandom));
        run_random_round(ROUND_ITEMS);
        write_reg(CFG_TIMEOUT_TICKS, 16'($urandom_range(2, 12)));
        write_reg(CFG_PING_CODE, 16'($urandom));
        write_reg(CFG_SPARE_2, 16'($urandom));
        write_reg(CFG_SPARE_3, 16'($urandom));
        run_random_round(ROUND_ITEMS);
    endtask

    // reset, tests in turn, then the verdict
    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_command <= CMD_BYTE;
        s_rx_byte <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_TIMEOUT_TICKS;
        cfg_data  <= 16'h0000;
        src_idle = 1'b0;
        snk_idle = 1'b0;
        hold_req = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_ping();
        test_short_ping();
        test_long_ping();
        test_dropped_frames();
        test_timeout();
        test_long_frame();
        test_backpressure();
        test_random_traffic();

        drain_replies();
        repeat (FINAL_WAIT) @(posedge aclk);
        if (reply_q.size() != 0)
            report_mismatch($sformatf("%0d reply bytes never arrived", reply_q.size()));

        $display("run: %0d input transactions (%0d ticks), %0d frames closed, %0d timeouts",
                 n_sent, n_ticks, n_frames, n_timeouts);
        $display("run: %0d reply bytes checked, %0d register writes, %0d mismatches",
                 n_reply_bytes, n_cfg_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
